// ----- sv/wf3_pkg.sv -----
// ----------------------------------------------------------------------------
// wf3_pkg
// Types, register codes and window arithmetic for the 3x3 window filter.
// ----------------------------------------------------------------------------
package wf3_pkg;

   localparam int DEF_MAX_WIDTH = 1024;

   localparam int LINE_WIDTH_W = 11;
   localparam int MODE_W       = 2;
   localparam int PIXEL_W      = 8;
   localparam int OUT_COL_W    = 10;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd1024;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_MIN   = 11'd2;

   // divide-by-nine as multiply and shift, exact for sums up to 9*255
   localparam logic [11:0] MEAN_RECIP = 12'd3641;
   localparam int          MEAN_SHIFT = 15;

   typedef enum logic {
      REG_LINE_WIDTH  = 1'b0,
      REG_FILTER_MODE = 1'b1
   } reg_index_type;

   typedef enum logic [MODE_W-1:0] {
      FILT_MEAN   = 2'd0,
      FILT_MEDIAN = 2'd1,
      FILT_MIN    = 2'd2,
      FILT_MAX    = 2'd3
   } filt_mode_type;

   typedef struct packed {
      logic               func;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   filtered_pixel;
      logic [OUT_COL_W-1:0] out_column;
      logic                 row_end;
      logic                 frame_end;
      logic                 last_in_run;
   } rsp_type;

   typedef logic [2:0][PIXEL_W-1:0] col3_type;   // one window column, rows top..bottom
   typedef logic [2:0][2:0][PIXEL_W-1:0] win_type; // columns oldest..newest
   typedef logic [8:0][PIXEL_W-1:0] pix9_type;

   function automatic logic [PIXEL_W-1:0] filter9(input pix9_type v,
                                                  input filt_mode_type mode);
      pix9_type           s;
      logic [PIXEL_W-1:0] t;
      logic [11:0]        sum;
      logic [23:0]        prod;
      logic [PIXEL_W-1:0] res;
      s   = v;
      sum = '0;
      for (int i = 0; i < 9; i++) begin
         sum = sum + 12'(v[i]);
      end
      // odd-even transposition sort, nine rounds of independent swaps
      for (int r = 0; r < 9; r++) begin
         for (int i = r % 2; i < 8; i += 2) begin
            if (s[i] > s[i+1]) begin
               t      = s[i];
               s[i]   = s[i+1];
               s[i+1] = t;
            end
         end
      end
      prod = 24'(sum) * 24'(MEAN_RECIP);
      case (mode)
         FILT_MEAN:   res = prod[MEAN_SHIFT +: PIXEL_W];
         FILT_MEDIAN: res = s[4];
         FILT_MIN:    res = s[0];
         FILT_MAX:    res = s[8];
         default:     res = s[4];
      endcase
      return res;
   endfunction

endpackage

// ----- sv/window_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// window_filter_3x3
// 3x3 mean / median / minimum / maximum filter on a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while the input is not stalled.
// Results for row r come out while row r+1 enters: nothing during the first row
// of a frame, none for the pixel in column zero, one for each later pixel and
// two for the last pixel of a row. The pair holds the input side while it
// drains; output stalls back up into the input. After the last row send
// line_width padding transactions (func = 1) to flush the bottom row; the last
// of them carries frame_end. Borders are mirrored about the edge pixel on each
// axis. The accept edge captures the pixel and the line store reads; the window
// update and filter result are registered when stage 1 retires, which output
// back-pressure can delay. Line stores are MAX_WIDTH x 8 bit memories and hold
// garbage after reset until the first row is written.
// ----------------------------------------------------------------------------
module window_filter_3x3 #(
   parameter int MAX_WIDTH = wf3_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wf3_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wf3_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wf3_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [wf3_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [wf3_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import wf3_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = (CW + 1 > LINE_WIDTH_W) ? CW + 1 : LINE_WIDTH_W;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_LATER  = 2'd2,
      PH_DRAIN  = 2'd3
   } phase_type;

   // configuration
   logic [LINE_WIDTH_W-1:0] line_width_ff;
   filt_mode_type           filter_mode_ff;
   logic                    csr_wr;

   // front control state
   logic [CW-1:0] col_ff, col_in;
   phase_type     phase_ff, phase_in;

   // stage 1
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [CW-1:0]      s1_col_ff;
   phase_type          s1_phase_ff;
   logic               s1_last_ff;
   logic               s1_go;

   // line stores
   logic [PIXEL_W-1:0] line_above[MAX_WIDTH];
   logic [PIXEL_W-1:0] line_current[MAX_WIDTH];
   logic [PIXEL_W-1:0] above_rd_ff, current_rd_ff;

   // window
   win_type win_ff, win_in;
   col3_type new_col;

   // output pair
   logic [1:0] out_cnt_ff, out_cnt_in;
   rsp_type    head_ff, head_in, tail_ff, tail_in;
   rsp_type    res0, res1;
   logic       has0, has1, pop;

   // front decode
   logic [WW-1:0] w_use, lw_ext;
   logic          accept, drop, last;
   phase_type     eff_phase;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      case (reg_index_type'(paddr[2]))
         REG_LINE_WIDTH:  prdata = CSR_DATA_W'(line_width_ff);
         REG_FILTER_MODE: prdata = CSR_DATA_W'(filter_mode_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RESET;
         filter_mode_ff <= FILT_MEAN;
      end else if (csr_wr) begin
         case (reg_index_type'(paddr[2]))
            REG_LINE_WIDTH:  line_width_ff  <= pwdata[LINE_WIDTH_W-1:0];
            REG_FILTER_MODE: filter_mode_ff <= filt_mode_type'(pwdata[MODE_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---- front: accept, advance column and phase, issue line store reads ----
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lw_ext = WW'(line_width_ff);
      if (lw_ext < WW'(LINE_WIDTH_MIN)) begin
         w_use = WW'(LINE_WIDTH_MIN);
      end else if (lw_ext > WW'(MAX_WIDTH)) begin
         w_use = WW'(MAX_WIDTH);
      end else begin
         w_use = lw_ext;
      end
      last = WW'(col_ff) >= (w_use - WW'(1));
      drop = req_data.func && (phase_ff == PH_FIRST || phase_ff == PH_SECOND);
      eff_phase = (req_data.func && phase_ff == PH_LATER) ? PH_DRAIN : phase_ff;

      col_in   = col_ff;
      phase_in = phase_ff;
      if (accept && !drop) begin
         if (last) begin
            col_in = '0;
            case (eff_phase)
               PH_FIRST: phase_in = PH_SECOND;
               PH_DRAIN: phase_in = PH_FIRST;
               default:  phase_in = PH_LATER;
            endcase
         end else begin
            col_in   = col_ff + CW'(1);
            phase_in = eff_phase;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = !drop;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         phase_ff    <= PH_FIRST;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         s1_px_ff    <= req_data.pixel;
         s1_col_ff   <= col_ff;
         s1_phase_ff <= eff_phase;
         s1_last_ff  <= last;
      end
   end

   // ---- line stores: read at accept, write when stage 1 retires ----
   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         above_rd_ff <= line_above[col_ff];
      end
      if (s1_go && (s1_phase_ff == PH_SECOND || s1_phase_ff == PH_LATER)) begin
         line_above[s1_col_ff] <= current_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         current_rd_ff <= line_current[col_ff];
      end
      if (s1_go && s1_phase_ff != PH_DRAIN) begin
         line_current[s1_col_ff] <= s1_px_ff;
      end
   end

   // ---- stage 1: window shift and filter ----
   assign pop   = rsp_valid && rsp_ready;
   assign s1_go = s1_valid_ff && (out_cnt_ff == 2'd0 || (out_cnt_ff == 2'd1 && pop));

   always_comb begin
      // rows top, middle, bottom; mirror the missing row about the center
      new_col[1] = current_rd_ff;
      case (s1_phase_ff)
         PH_SECOND: begin
            new_col[0] = s1_px_ff;
            new_col[2] = s1_px_ff;
         end
         PH_LATER: begin
            new_col[0] = above_rd_ff;
            new_col[2] = s1_px_ff;
         end
         default: begin
            new_col[0] = above_rd_ff;
            new_col[2] = above_rd_ff;
         end
      endcase
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = new_col;

      has0 = s1_phase_ff != PH_FIRST && s1_col_ff != '0;
      has1 = s1_phase_ff != PH_FIRST && s1_last_ff;

      // left column mirrors to the right one at column zero
      res0.filtered_pixel = filter9({(s1_col_ff == CW'(1)) ? win_in[2] : win_in[0],
                                     win_in[1], win_in[2]}, filter_mode_ff);
      res0.out_column     = OUT_COL_W'(s1_col_ff - CW'(1));
      res0.row_end        = 1'b0;
      res0.frame_end      = 1'b0;
      res0.last_in_run    = !s1_last_ff;

      // right edge: mirror the column left of center
      res1.filtered_pixel = filter9({win_in[1], win_in[2], win_in[1]}, filter_mode_ff);
      res1.out_column     = OUT_COL_W'(s1_col_ff);
      res1.row_end        = 1'b1;
      res1.frame_end      = s1_phase_ff == PH_DRAIN;
      res1.last_in_run    = 1'b1;

      out_cnt_in = out_cnt_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      if (s1_go) begin
         out_cnt_in = 2'(has0) + 2'(has1);
         head_in    = has0 ? res0 : res1;
         tail_in    = res1;
      end else if (pop) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         head_in    = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (s1_go && s1_phase_ff != PH_FIRST) begin
            win_ff <= win_in;
         end
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid = out_cnt_ff != 2'd0;
   assign rsp_data  = head_ff;

endmodule
